// ===== design/tes_pkg.sv =====
`timescale 1ns / 1ps
package tes_pkg;

   localparam logic [1:0] OP_ELAPSED_US = 2'd0;
   localparam logic [1:0] OP_ELAPSED_MS = 2'd1;
   localparam logic [1:0] OP_STOPWATCH  = 2'd2;

   localparam logic [19:0] US_PER_SEC     = 20'd1000000;
   localparam logic [20:0] US_PER_TWO_SEC = 21'd2000000;
   localparam logic [5:0]  SEC_PER_MIN    = 6'd60;
   localparam logic [5:0]  MAX_DIGIT      = 6'd59;
   localparam logic [15:0] MAX_HOURS      = 16'hFFFF;

   // exact reciprocals: q = (x * RECIP) >> shift
   localparam logic [29:0] RECIP_US   = 30'd70368745;   // (p >> 6) / 15625, shift 40
   localparam logic [29:0] RECIP_MS   = 30'd549755814;  // (p >> 3) / 125, shift 36
   localparam logic [21:0] RECIP_60   = 22'd2236963;    // (t >> 2) / 15, shift 25
   localparam logic [19:0] RECIP_3600 = 20'd596524;     // (t >> 4) / 225, shift 27

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] start_hours;
      logic [5:0]  start_minutes;
      logic [5:0]  start_seconds;
      logic [19:0] start_micros;
      logic [15:0] now_hours;
      logic [5:0]  now_minutes;
      logic [5:0]  now_seconds;
      logic [19:0] now_micros;
      logic [31:0] period;
   } tes_req_type;

   typedef struct packed {
      logic        expired;
      logic [15:0] diff_hours;
      logic [5:0]  diff_minutes;
      logic [5:0]  diff_seconds;
      logic [19:0] diff_micros;
      logic        before_start;
   } tes_rsp_type;

   typedef struct packed {
      logic [16:0] hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
      logic [19:0] micros;
   } tes_time_type;

   typedef struct packed {
      logic        zero;
      logic        kzero;
      logic [22:0] secs;
      logic [22:0] tsec;
      logic [16:0] q60;
      logic [10:0] q3600;
      logic [19:0] micros;
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [16:0] hours;
   } tes_exp_type;

endpackage

// ===== design/timestamp_elapsed_and_stopwatch_top.sv =====
`timescale 1ns / 1ps
// Timestamp elapsed check and stopwatch.
// Input channel: a word on req_word is taken at a rising edge where start is high
// and busy is low. busy is high only while reset is held, so one word can be taken
// every cycle.
// Operations: elapsed check with the period in microseconds or in milliseconds
// (start plus period, carried through seconds, minutes and hours, then compared
// with the current time), and stopwatch (current minus start, split into hours,
// minutes, seconds and microseconds, saturating, flagged when current is earlier).
// Result channel: every word taken gives exactly one result word on rsp_word, shown
// with rsp_strobe for one cycle. The receiver cannot stall, so results are never
// held back.
// Pipeline: seven stages (input register, period split multiply,
// remainder, divide by 60, divide by 3600, minute carry and stopwatch subtract,
// compare and result register). Throughput is one word per cycle.
// Reset: synchronous, active high. It drops every word in flight, and no result
// appears for those words.
module timestamp_elapsed_and_stopwatch_top
   import tes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  tes_req_type req_word,
   output logic        rsp_strobe,
   output tes_rsp_type rsp_word
);

   localparam int STAGES = 7;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   tes_req_type       word_ff [0:5];
   tes_exp_type       ex_ff [1:5];
   tes_exp_type       ex_in [1:5];
   tes_time_type      nrm_start_ff, nrm_start_in;
   tes_time_type      nrm_now_ff, nrm_now_in;
   tes_rsp_type       sw_ff, sw_in;
   tes_rsp_type       rsp_ff, rsp_in;

   logic        is_ms1;
   logic [28:0] mul_a1;
   logic [29:0] mul_b1;
   logic [58:0] prod1;

   logic        is_ms2;
   logic [19:0] pus_lo2;
   logic [19:0] qm_lo2;
   logic [19:0] rem2;
   logic [20:0] tot2;
   logic [1:0]  extra2;

   logic [5:0]  sec_base3;
   logic [42:0] prod3;

   logic [38:0] prod4;
   logic [5:0]  sub60_4;
   logic [5:0]  sec_mod4;

   logic [5:0]  sub60_5;
   logic [5:0]  cm_lo5;
   logic [5:0]  min_base5;
   logic [6:0]  msum5;
   logic        wrap5;
   logic [10:0] ch5;
   logic [20:0] du5;
   logic [6:0]  ds5;
   logic [6:0]  dm5;
   logic [17:0] dh5;

   logic        ge6;

   function automatic tes_time_type norm_time(input logic [15:0] hours,
                                              input logic [5:0]  minutes,
                                              input logic [5:0]  seconds,
                                              input logic [19:0] micros);
      tes_time_type t;
      logic         c_us;
      logic [6:0]   s_sum;
      logic         c_s;
      logic [6:0]   m_sum;
      logic         c_m;
      c_us     = (micros >= US_PER_SEC);
      t.micros = c_us ? 20'(micros - US_PER_SEC) : micros;
      s_sum     = {1'b0, seconds} + {6'd0, c_us};
      c_s       = (s_sum >= {1'b0, SEC_PER_MIN});
      t.seconds = c_s ? 6'(s_sum - {1'b0, SEC_PER_MIN}) : s_sum[5:0];
      m_sum     = {1'b0, minutes} + {6'd0, c_s};
      c_m       = (m_sum >= {1'b0, SEC_PER_MIN});
      t.minutes = c_m ? 6'(m_sum - {1'b0, SEC_PER_MIN}) : m_sum[5:0];
      t.hours   = {1'b0, hours} + {16'd0, c_m};
      return t;
   endfunction

   assign busy     = reset;
   assign valid_in = {valid_ff[STAGES-2:0], start & ~busy};

   // split the period into whole seconds
   always_comb begin
      is_ms1    = (word_ff[0].operation == OP_ELAPSED_MS);
      mul_a1    = is_ms1 ? word_ff[0].period[31:3] : {3'b000, word_ff[0].period[31:6]};
      mul_b1    = is_ms1 ? RECIP_MS : RECIP_US;
      prod1     = mul_a1 * mul_b1;
      ex_in[1]  = '0;
      ex_in[1].zero = (word_ff[0].period == '0);
      ex_in[1].secs = is_ms1 ? prod1[58:36] : {10'd0, prod1[52:40]};
   end

   // sub-second remainder plus start microseconds
   always_comb begin
      is_ms2  = (word_ff[1].operation == OP_ELAPSED_MS);
      pus_lo2 = is_ms2 ? ({word_ff[1].period[9:0], 10'd0}
                          - {word_ff[1].period[15:0], 4'd0}
                          - {word_ff[1].period[16:0], 3'd0})
                       : word_ff[1].period[19:0];
      qm_lo2  = ex_ff[1].secs[19:0] * US_PER_SEC;
      rem2    = pus_lo2 - qm_lo2;
      tot2    = {1'b0, word_ff[1].start_micros} + {1'b0, rem2};
      ex_in[2] = ex_ff[1];
      if (tot2 >= US_PER_TWO_SEC) begin
         extra2 = 2'd2;
         ex_in[2].micros = 20'(tot2 - US_PER_TWO_SEC);
      end else if (tot2 >= {1'b0, US_PER_SEC}) begin
         extra2 = 2'd1;
         ex_in[2].micros = 20'(tot2 - {1'b0, US_PER_SEC});
      end else begin
         extra2 = 2'd0;
         ex_in[2].micros = tot2[19:0];
      end
      ex_in[2].secs = ex_ff[1].secs + {21'd0, extra2};
   end

   // carry seconds into minutes
   always_comb begin
      sec_base3 = (word_ff[2].start_seconds > MAX_DIGIT) ? MAX_DIGIT
                                                         : word_ff[2].start_seconds;
      ex_in[3]       = ex_ff[2];
      ex_in[3].kzero = (ex_ff[2].secs == '0);
      ex_in[3].tsec  = ex_ff[2].secs + {17'd0, sec_base3};
      prod3          = ex_in[3].tsec[22:2] * RECIP_60;
      ex_in[3].q60   = prod3[41:25];
   end

   // carries into hours, expiry seconds, stopwatch normalize
   always_comb begin
      prod4    = ex_ff[3].tsec[22:4] * RECIP_3600;
      sub60_4  = ex_ff[3].q60[5:0] * SEC_PER_MIN;
      sec_mod4 = ex_ff[3].tsec[5:0] - sub60_4;
      ex_in[4] = ex_ff[3];
      ex_in[4].q3600   = prod4[37:27];
      ex_in[4].seconds = ex_ff[3].kzero ? word_ff[3].start_seconds : sec_mod4;
      nrm_start_in = norm_time(word_ff[3].start_hours, word_ff[3].start_minutes,
                               word_ff[3].start_seconds, word_ff[3].start_micros);
      nrm_now_in   = norm_time(word_ff[3].now_hours, word_ff[3].now_minutes,
                               word_ff[3].now_seconds, word_ff[3].now_micros);
   end

   // expiry minutes and hours
   always_comb begin
      sub60_5   = ex_ff[4].q3600[5:0] * SEC_PER_MIN;
      cm_lo5    = ex_ff[4].q60[5:0] - sub60_5;
      min_base5 = (word_ff[4].start_minutes > MAX_DIGIT) ? MAX_DIGIT
                                                         : word_ff[4].start_minutes;
      msum5     = {1'b0, min_base5} + {1'b0, cm_lo5};
      wrap5     = (msum5 >= {1'b0, SEC_PER_MIN});
      ch5       = ex_ff[4].q3600 + {10'd0, wrap5};
      ex_in[5]  = ex_ff[4];
      if (ex_ff[4].q60 == '0) begin
         ex_in[5].minutes = word_ff[4].start_minutes;
      end else begin
         ex_in[5].minutes = wrap5 ? 6'(msum5 - {1'b0, SEC_PER_MIN}) : msum5[5:0];
      end
      ex_in[5].hours = {1'b0, word_ff[4].start_hours} + {6'd0, ch5};
   end

   // stopwatch subtract with borrows
   always_comb begin
      du5     = {1'b0, nrm_now_ff.micros} - {1'b0, nrm_start_ff.micros};
      ds5     = {1'b0, nrm_now_ff.seconds} - {1'b0, nrm_start_ff.seconds}
                - {6'd0, du5[20]};
      dm5     = {1'b0, nrm_now_ff.minutes} - {1'b0, nrm_start_ff.minutes}
                - {6'd0, ds5[6]};
      dh5     = {1'b0, nrm_now_ff.hours} - {1'b0, nrm_start_ff.hours}
                - {17'd0, dm5[6]};
      sw_in   = '0;
      if (dh5[17]) begin
         sw_in.before_start = 1'b1;
      end else if (dh5[16]) begin
         sw_in.diff_hours   = MAX_HOURS;
         sw_in.diff_minutes = MAX_DIGIT;
         sw_in.diff_seconds = MAX_DIGIT;
         sw_in.diff_micros  = US_PER_SEC - 20'd1;
      end else begin
         sw_in.diff_hours   = dh5[15:0];
         sw_in.diff_minutes = dm5[6] ? 6'(dm5[5:0] + SEC_PER_MIN) : dm5[5:0];
         sw_in.diff_seconds = ds5[6] ? 6'(ds5[5:0] + SEC_PER_MIN) : ds5[5:0];
         sw_in.diff_micros  = du5[20] ? 20'(du5[19:0] + US_PER_SEC) : du5[19:0];
      end
   end

   // compare and select
   always_comb begin
      ge6 = ({1'b0, word_ff[5].now_hours, word_ff[5].now_minutes,
              word_ff[5].now_seconds, word_ff[5].now_micros}
             >= {ex_ff[5].hours, ex_ff[5].minutes, ex_ff[5].seconds, ex_ff[5].micros});
      rsp_in = '0;
      case (word_ff[5].operation)
         OP_ELAPSED_US, OP_ELAPSED_MS: begin
            rsp_in.expired = ex_ff[5].zero | ge6;
         end
         OP_STOPWATCH: begin
            rsp_in = sw_ff;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff[0] <= req_word;
      for (int i = 1; i < 6; i++) begin
         word_ff[i] <= word_ff[i-1];
      end
      for (int j = 1; j < 6; j++) begin
         ex_ff[j] <= ex_in[j];
      end
      nrm_start_ff <= nrm_start_in;
      nrm_now_ff   <= nrm_now_in;
      sw_ff        <= sw_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = valid_ff[STAGES-1];
   assign rsp_word   = rsp_ff;

   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, STAGES))
      else $error("result strobe without a matching accepted word");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.diff_minutes < SEC_PER_MIN
                      && rsp_word.diff_seconds < SEC_PER_MIN
                      && rsp_word.diff_micros < US_PER_SEC))
      else $error("stopwatch digit out of range");

   a_before_start_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.before_start |->
         (!rsp_word.expired && rsp_word.diff_hours == '0
          && rsp_word.diff_minutes == '0 && rsp_word.diff_seconds == '0
          && rsp_word.diff_micros == '0))
      else $error("before_start result carries a nonzero field");

   a_expiry_seconds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && !ex_ff[4].kzero |-> ex_ff[4].seconds < SEC_PER_MIN)
      else $error("expiry seconds out of range after carry");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench
   import tes_pkg::*;
();

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam longint unsigned US_MINUTE = 64'd60000000;
   localparam longint unsigned US_HOUR   = 64'd3600000000;
   localparam int unsigned RANDOM_WORDS = 1650;

   localparam tes_rsp_type RSP_ZERO    = '0;
   localparam tes_rsp_type RSP_ELAPSED = '{1'b1, 16'd0, 6'd0, 6'd0, 20'd0, 1'b0};
   localparam tes_rsp_type RSP_EARLY   = '{1'b0, 16'd0, 6'd0, 6'd0, 20'd0, 1'b1};
   localparam tes_rsp_type RSP_FULL    = '{1'b0, 16'hFFFF, 6'd59, 6'd59, 20'd999999, 1'b0};

   typedef struct packed {
      logic [15:0] h;
      logic [5:0]  m;
      logic [5:0]  s;
      logic [19:0] u;
   } stamp_type;

   typedef struct {
      tes_req_type word;
      bit          typed;
      tes_rsp_type result;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   tes_req_type req_word;
   logic        rsp_strobe;
   tes_rsp_type rsp_word;

   tes_rsp_type      expected_results[$];
   directed_row_type directed_rows[$];
   int unsigned      failures = 0;
   int unsigned      gap_percent = 6;

   timestamp_elapsed_and_stopwatch_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic stamp_type stamp(input int unsigned h, m, s, u);
      stamp_type t;
      t.h = 16'(h);
      t.m = 6'(m);
      t.s = 6'(s);
      t.u = 20'(u);
      return t;
   endfunction

   function automatic tes_req_type make_word(input logic [1:0] op, input stamp_type st,
                                             input stamp_type nw, input logic [31:0] period);
      tes_req_type w;
      w.operation     = op;
      w.start_hours   = st.h;
      w.start_minutes = st.m;
      w.start_seconds = st.s;
      w.start_micros  = st.u;
      w.now_hours     = nw.h;
      w.now_minutes   = nw.m;
      w.now_seconds   = nw.s;
      w.now_micros    = nw.u;
      w.period        = period;
      return w;
   endfunction

   function automatic longint unsigned stamp_micros(input longint unsigned h, m, s, u);
      return u + s * US_PER_SEC + m * US_MINUTE + h * US_HOUR;
   endfunction

   // advance a base-60 digit by k carries; out-of-range digits wrap on the first one
   function automatic longint unsigned carry_digit(input longint unsigned v, k,
                                                   output longint unsigned digit);
      if (k == 0) begin
         digit = v;
         return 0;
      end
      if (v <= MAX_DIGIT) begin
         digit = (v + k) % SEC_PER_MIN;
         return (v + k) / SEC_PER_MIN;
      end
      digit = (k - 1) % SEC_PER_MIN;
      return 1 + (k - 1) / SEC_PER_MIN;
   endfunction

   function automatic tes_rsp_type predict_result(input tes_req_type w);
      tes_rsp_type       r;
      longint unsigned   span, us, secs, mins, to_min, to_hour, exp_h;
      longint unsigned   first, last, delta, hrs;
      r = RSP_ZERO;
      case (w.operation)
         OP_ELAPSED_US, OP_ELAPSED_MS: begin
            span = (w.operation == OP_ELAPSED_MS) ? 64'(w.period) * 1000 : 64'(w.period);
            if (span == 0) begin
               r.expired = 1'b1;
            end else begin
               us      = w.start_micros + span;
               to_min  = carry_digit(w.start_seconds, us / US_PER_SEC, secs);
               to_hour = carry_digit(w.start_minutes, to_min, mins);
               exp_h   = w.start_hours + to_hour;
               if (w.now_hours != exp_h)
                  r.expired = (w.now_hours > exp_h);
               else if (w.now_minutes != mins)
                  r.expired = (w.now_minutes > mins);
               else if (w.now_seconds != secs)
                  r.expired = (w.now_seconds > secs);
               else
                  r.expired = (w.now_micros >= us % US_PER_SEC);
            end
         end
         OP_STOPWATCH: begin
            first = stamp_micros(w.start_hours, w.start_minutes, w.start_seconds,
                                 w.start_micros);
            last  = stamp_micros(w.now_hours, w.now_minutes, w.now_seconds, w.now_micros);
            if (last < first) begin
               r.before_start = 1'b1;
            end else begin
               delta = last - first;
               secs  = delta / US_PER_SEC;
               hrs   = secs / 3600;
               if (hrs > MAX_HOURS) begin
                  r = RSP_FULL;
               end else begin
                  r.diff_hours   = 16'(hrs);
                  r.diff_minutes = 6'((secs / 60) % 60);
                  r.diff_seconds = 6'(secs % 60);
                  r.diff_micros  = 20'(delta % US_PER_SEC);
               end
            end
         end
         default: r = RSP_ZERO;
      endcase
      return r;
   endfunction

   function automatic stamp_type split_micros(input longint unsigned t);
      if (t / US_HOUR > MAX_HOURS)
         return stamp(65535, 63, 63, 1048575);
      return stamp(32'(t / US_HOUR), 32'((t / US_MINUTE) % 60),
                   32'((t / US_PER_SEC) % 60), 32'(t % US_PER_SEC));
   endfunction

   function automatic stamp_type random_stamp();
      stamp_type t;
      case ($urandom_range(3))
         0:       t.h = 16'($urandom_range(3));
         1:       t.h = MAX_HOURS - 16'($urandom_range(3));
         default: t.h = 16'($urandom);
      endcase
      t.m = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
      t.s = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
      t.u = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(999999));
      return t;
   endfunction

   function automatic logic [31:0] random_period();
      case ($urandom_range(5))
         0:       return 32'($urandom_range(1));
         1:       return 32'($urandom_range(2000));
         2:       return 32'($urandom_range(4000000));
         3:       return 32'hFFFFFFFF - 32'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   // most words put the current time right at, or near, the expiry or start
   function automatic tes_req_type random_word();
      logic [1:0]      op;
      stamp_type       st, nw;
      logic [31:0]     period;
      longint unsigned base, target;
      op     = ($urandom_range(19) == 0) ? OP_RESERVED : 2'($urandom_range(2));
      st     = random_stamp();
      nw     = random_stamp();
      period = random_period();
      if ($urandom_range(3) != 0) begin
         base = stamp_micros(st.h, st.m, st.s, st.u);
         case (op)
            OP_ELAPSED_US, OP_ELAPSED_MS: begin
               target = base + ((op == OP_ELAPSED_MS) ? 64'(period) * 1000 : 64'(period));
               target = target + $urandom_range(4);
               target = (target >= 2) ? target - 2 : target;
            end
            OP_STOPWATCH: begin
               case ($urandom_range(4))
                  0:       target = base + $urandom_range(5000000);
                  1:       target = base + $urandom;
                  2:       target = base + longint'($urandom_range(300000)) * US_PER_SEC;
                  3:       target = base + longint'($urandom) * US_MINUTE;
                  default: target = (base > 1000) ? base - $urandom_range(1, 1000) : base;
               endcase
            end
            default: target = base;
         endcase
         nw = split_micros(target);
      end
      return make_word(op, st, nw, period);
   endfunction

   task automatic add_row(input logic [1:0] op, input stamp_type st, input stamp_type nw,
                          input logic [31:0] period, input bit typed,
                          input tes_rsp_type result);
      directed_row_type row;
      row.word   = make_word(op, st, nw, period);
      row.typed  = typed;
      row.result = result;
      directed_rows.push_back(row);
   endtask

   task automatic send_word(input tes_req_type w, input tes_rsp_type want);
      while ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      expected_results.push_back(want);
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      tes_rsp_type want;
      if (rsp_strobe === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result word with nothing outstanding");
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("expired", want.expired, rsp_word.expired);
            check_field("diff_hours", want.diff_hours, rsp_word.diff_hours);
            check_field("diff_minutes", want.diff_minutes, rsp_word.diff_minutes);
            check_field("diff_seconds", want.diff_seconds, rsp_word.diff_seconds);
            check_field("diff_micros", want.diff_micros, rsp_word.diff_micros);
            check_field("before_start", want.before_start, rsp_word.before_start);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      tes_req_type w;
      int unsigned drain;
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;

      add_row(OP_ELAPSED_US, stamp(65535, 59, 59, 999999), stamp(0, 0, 0, 0), 0, 1'b1,
              RSP_ELAPSED);
      add_row(OP_ELAPSED_MS, stamp(65535, 63, 63, 1048575), stamp(0, 0, 0, 0), 0, 1'b1,
              RSP_ELAPSED);
      add_row(OP_STOPWATCH, stamp(0, 0, 0, 0), stamp(0, 0, 0, 0), 32'hFFFFFFFF, 1'b1,
              RSP_ZERO);
      add_row(OP_STOPWATCH, stamp(0, 0, 0, 0), stamp(65535, 59, 59, 999999), 0, 1'b1,
              RSP_FULL);
      add_row(OP_STOPWATCH, stamp(1, 0, 0, 0), stamp(0, 59, 59, 999999), 0, 1'b1,
              RSP_EARLY);
      add_row(OP_RESERVED, stamp(65535, 63, 63, 1048575), stamp(65535, 63, 63, 1048575),
              32'hFFFFFFFF, 1'b1, RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(1, 2, 3, 4), stamp(1, 2, 3, 9), 5, 1'b1, RSP_ELAPSED);
      add_row(OP_ELAPSED_US, stamp(1, 2, 3, 4), stamp(1, 2, 3, 9), 6, 1'b1, RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(65535, 59, 59, 999999), stamp(65535, 59, 59, 999999), 1,
              1'b0, RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(0, 0, 0, 0), stamp(65535, 59, 59, 999999), 32'hFFFFFFFF,
              1'b0, RSP_ZERO);
      add_row(OP_ELAPSED_MS, stamp(0, 0, 0, 0), stamp(65535, 59, 59, 999999), 32'hFFFFFFFF,
              1'b0, RSP_ZERO);
      add_row(OP_ELAPSED_MS, stamp(0, 0, 0, 999500), stamp(0, 0, 1, 499), 1, 1'b0,
              RSP_ZERO);
      add_row(OP_ELAPSED_MS, stamp(0, 0, 0, 999500), stamp(0, 0, 1, 500), 1, 1'b0,
              RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(0, 0, 63, 999999), stamp(0, 1, 0, 0), 1, 1'b0, RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(0, 60, 59, 999999), stamp(1, 0, 0, 0), 1, 1'b0,
              RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(0, 0, 0, 1048575), stamp(0, 0, 1, 48576), 1, 1'b0,
              RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(0, 0, 0, 0), stamp(65535, 63, 63, 1048575), 1, 1'b0,
              RSP_ZERO);
      add_row(OP_STOPWATCH, stamp(0, 0, 0, 0), stamp(65535, 63, 63, 1048575), 0, 1'b0,
              RSP_ZERO);
      add_row(OP_STOPWATCH, stamp(0, 63, 63, 1048575), stamp(2, 0, 0, 0), 0, 1'b0,
              RSP_ZERO);
      add_row(OP_STOPWATCH, stamp(12, 34, 56, 789012), stamp(13, 0, 0, 0), 7, 1'b0,
              RSP_ZERO);
      add_row(OP_ELAPSED_MS, stamp(5, 0, 0, 0), stamp(6, 0, 0, 0), 3600000, 1'b0,
              RSP_ZERO);
      add_row(OP_ELAPSED_US, stamp(0, 0, 0, 1), stamp(0, 1, 0, 0), 59999999, 1'b0,
              RSP_ZERO);
      add_row(OP_STOPWATCH, stamp(65535, 59, 59, 999999), stamp(65535, 59, 59, 999999), 0,
              1'b0, RSP_ZERO);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word,
                   directed_rows[i].typed ? directed_rows[i].result
                                          : predict_result(directed_rows[i].word));

      for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 3)
            gap_percent = 84;
         else if (n == 2 * RANDOM_WORDS / 3)
            gap_percent = 0;
         w = random_word();
         send_word(w, predict_result(w));
      end
      start <= 1'b0;

      drain = 0;
      while (expected_results.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (12) @(posedge clock);

      if (failures == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (expected_results.size() != 0)
            $error("%0d result words never arrived", expected_results.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/tes_pkg.sv
design/timestamp_elapsed_and_stopwatch_top.sv
sim/testbench.sv
